[rtl/core/ghr_pkg.sv]
package ghr_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int CELLS = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int ROW_W = 3;
  localparam int COL_W = 3;
  localparam int TEMP_W = 32;
  localparam int SUM_W = TEMP_W + 2;
  localparam int TOL_W = 31;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LIMIT = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;
  localparam logic [CNT_W-1:0] SWEEP_CAP = 16'hFFFF;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  load_en;
    addr_t load_addr;
    logic  acc_clear;
    logic  acc_add;
    logic  upd_en;
    addr_t upd_addr;
    logic  flip_bank;
  } ghr_cmd_t;

  typedef struct packed {
    logic over_tol;
  } ghr_stat_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             stable;
    logic [CNT_W-1:0] sweeps_done;
    logic             last;
  } ghr_out_ctl_t;

endpackage

[rtl/core/ghr_if.sv]
interface ghr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [ghr_pkg::TEMP_W-1:0]   temperature;

  modport source (output valid, kind, temperature, input ready);
  modport sink   (input valid, kind, temperature, output ready);
endinterface

interface ghr_out_if;
  logic                                valid;
  logic                                ready;
  logic [ghr_pkg::ROW_W-1:0]           row;
  logic [ghr_pkg::COL_W-1:0]           col;
  logic signed [ghr_pkg::TEMP_W-1:0]   cell_value;
  logic                                stable;
  logic [ghr_pkg::CNT_W-1:0]           sweeps_done;
  logic                                last;

  modport source (output valid, row, col, cell_value, stable, sweeps_done, last, input ready);
  modport sink   (input valid, row, col, cell_value, stable, sweeps_done, last, output ready);
endinterface

interface ghr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ghr_pkg::CFG_IDX_W-1:0]       index;
  logic [ghr_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ghr_datapath.sv]
module ghr_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ghr_pkg::ghr_cmd_t            cmd,
  input  logic [ghr_pkg::TEMP_W-1:0]   load_data,
  input  logic [ghr_pkg::TOL_W-1:0]    tolerance,
  output ghr_pkg::ghr_stat_t           stat,
  output logic [ghr_pkg::TEMP_W-1:0]   rd_data
);

  // Two banks: a sweep reads one and writes the other, then the roles swap.
  // Edge cells are written to both banks on load and never change.
  logic [ghr_pkg::TEMP_W-1:0] mem_a [ghr_pkg::CELLS];
  logic [ghr_pkg::TEMP_W-1:0] mem_b [ghr_pkg::CELLS];

  logic                        bank_r;
  logic [ghr_pkg::TEMP_W-1:0]  rd_a_r;
  logic [ghr_pkg::TEMP_W-1:0]  rd_b_r;
  logic [ghr_pkg::SUM_W-1:0]   sum_r;

  logic [ghr_pkg::TEMP_W-1:0]  new_val;
  logic [ghr_pkg::TEMP_W:0]    diff_pos;
  logic [ghr_pkg::TEMP_W:0]    diff_neg;
  logic [ghr_pkg::TEMP_W:0]    diff_mag;
  logic [ghr_pkg::SUM_W-1:0]   rd_ext;

  always_comb begin
    rd_data  = bank_r ? rd_b_r : rd_a_r;
    rd_ext   = {{2{rd_data[ghr_pkg::TEMP_W-1]}}, rd_data};
    // Dropping the two low bits of the sum floors the quarter towards minus infinity.
    new_val  = sum_r[ghr_pkg::TEMP_W+1:2];
    diff_pos = {new_val[ghr_pkg::TEMP_W-1], new_val} - {rd_data[ghr_pkg::TEMP_W-1], rd_data};
    diff_neg = {rd_data[ghr_pkg::TEMP_W-1], rd_data} - {new_val[ghr_pkg::TEMP_W-1], new_val};
    diff_mag = diff_pos[ghr_pkg::TEMP_W] ? diff_neg : diff_pos;
    stat.over_tol = diff_mag > (ghr_pkg::TEMP_W+1)'(tolerance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (cmd.flip_bank) begin
      bank_r <= ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem_a[cmd.load_addr] <= load_data;
    end else if (cmd.upd_en && bank_r) begin
      mem_a[cmd.upd_addr] <= new_val;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem_a[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem_b[cmd.load_addr] <= load_data;
    end else if (cmd.upd_en && !bank_r) begin
      mem_b[cmd.upd_addr] <= new_val;
    end
    if (cmd.rd_en) begin
      rd_b_r <= mem_b[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      sum_r <= rd_ext;
    end else if (cmd.acc_add) begin
      sum_r <= sum_r + rd_ext;
    end
  end

endmodule

[rtl/core/ghr_ctrl.sv]
module ghr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  ghr_in_if.sink                      in_chan,
  ghr_cfg_if.sink                     cfg_chan,
  input  logic                        out_ready,
  input  ghr_pkg::ghr_stat_t          stat,
  output ghr_pkg::ghr_cmd_t           cmd,
  output ghr_pkg::ghr_out_ctl_t       out_ctl,
  output logic [ghr_pkg::TOL_W-1:0]   tolerance
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_SWEEP    = 4'b0010,
    S_OUT_RD   = 4'b0100,
    S_OUT_SEND = 4'b1000
  } state_t;

  localparam logic [ghr_pkg::STEP_W-1:0] STEP_UP     = 3'd0;
  localparam logic [ghr_pkg::STEP_W-1:0] STEP_DOWN   = 3'd1;
  localparam logic [ghr_pkg::STEP_W-1:0] STEP_LEFT   = 3'd2;
  localparam logic [ghr_pkg::STEP_W-1:0] STEP_RIGHT  = 3'd3;
  localparam logic [ghr_pkg::STEP_W-1:0] STEP_CENTRE = 3'd4;
  localparam logic [ghr_pkg::STEP_W-1:0] STEP_UPDATE = 3'd5;

  localparam logic [ghr_pkg::ADDR_W-1:0] ADDR_COLS  = ghr_pkg::ADDR_W'(ghr_pkg::COLS);
  localparam logic [ghr_pkg::ADDR_W-1:0] ADDR_FIRST = ghr_pkg::ADDR_W'(ghr_pkg::COLS + 1);
  localparam logic [ghr_pkg::ADDR_W-1:0] ADDR_LAST  = ghr_pkg::ADDR_W'(ghr_pkg::CELLS - 1);
  localparam logic [ghr_pkg::ROW_W-1:0]  ROW_INNER_LAST = ghr_pkg::ROW_W'(ghr_pkg::ROWS - 2);
  localparam logic [ghr_pkg::COL_W-1:0]  COL_INNER_LAST = ghr_pkg::COL_W'(ghr_pkg::COLS - 2);
  localparam logic [ghr_pkg::COL_W-1:0]  COL_LAST       = ghr_pkg::COL_W'(ghr_pkg::COLS - 1);

  state_t                         state_r, state_nxt;
  logic [ghr_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [ghr_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [ghr_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [ghr_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [ghr_pkg::ADDR_W-1:0]     load_idx_r, load_idx_nxt;
  logic [ghr_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           calm_r, calm_nxt;
  logic                           stable_r, stable_nxt;
  logic [ghr_pkg::TOL_W-1:0]      tol_r;
  logic [ghr_pkg::CNT_W-1:0]      limit_r;

  logic                           in_acc;
  logic                           calm_now;
  logic [ghr_pkg::CNT_W-1:0]      count_inc;
  logic [ghr_pkg::CNT_W-1:0]      eff_limit;

  assign cfg_chan.ready = rst_n;
  assign in_chan.ready  = rst_n && (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign tolerance      = tol_r;

  assign eff_limit = (limit_r == '0) ? ghr_pkg::SWEEP_CAP : limit_r;
  assign count_inc = count_r + 1'b1;
  assign calm_now  = calm_r && !stat.over_tol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= ghr_pkg::TOL_RESET;
      limit_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        ghr_pkg::CFG_TOLERANCE:   tol_r   <= cfg_chan.data[ghr_pkg::TOL_W-1:0];
        ghr_pkg::CFG_SWEEP_LIMIT: limit_r <= cfg_chan.data[ghr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    addr_nxt     = addr_r;
    load_idx_nxt = load_idx_r;
    count_nxt    = count_r;
    calm_nxt     = calm_r;
    stable_nxt   = stable_r;
    cmd          = '0;
    cmd.load_addr = load_idx_r;
    cmd.upd_addr  = addr_r;
    cmd.rd_addr   = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.kind == ghr_pkg::KIND_LOAD) begin
            cmd.load_en  = 1'b1;
            load_idx_nxt = (load_idx_r == ADDR_LAST) ? '0 : load_idx_r + 1'b1;
          end else begin
            load_idx_nxt = '0;
            row_nxt      = ghr_pkg::ROW_W'(1);
            col_nxt      = ghr_pkg::COL_W'(1);
            addr_nxt     = ADDR_FIRST;
            step_nxt     = STEP_UP;
            calm_nxt     = 1'b1;
            count_nxt    = '0;
            state_nxt    = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        step_nxt = step_r + 1'b1;
        unique case (step_r)
          STEP_UP: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = addr_r - ADDR_COLS;
          end
          STEP_DOWN: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = addr_r + ADDR_COLS;
            cmd.acc_clear = 1'b1;
          end
          STEP_LEFT: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = addr_r - 1'b1;
            cmd.acc_add = 1'b1;
          end
          STEP_RIGHT: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = addr_r + 1'b1;
            cmd.acc_add = 1'b1;
          end
          STEP_CENTRE: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = addr_r;
            cmd.acc_add = 1'b1;
          end
          STEP_UPDATE: begin
            // The centre value is on the read port now; write the new value
            // to the other bank and fold the change test into the calm flag.
            cmd.upd_en = 1'b1;
            step_nxt   = STEP_UP;
            calm_nxt   = calm_now;
            if (col_r == COL_INNER_LAST) begin
              if (row_r == ROW_INNER_LAST) begin
                cmd.flip_bank = 1'b1;
                count_nxt     = count_inc;
                if (calm_now || count_inc >= eff_limit) begin
                  stable_nxt = calm_now;
                  row_nxt    = '0;
                  col_nxt    = '0;
                  addr_nxt   = '0;
                  state_nxt  = S_OUT_RD;
                end else begin
                  calm_nxt = 1'b1;
                  row_nxt  = ghr_pkg::ROW_W'(1);
                  col_nxt  = ghr_pkg::COL_W'(1);
                  addr_nxt = ADDR_FIRST;
                end
              end else begin
                // Skip the right edge of this row and the left edge of the next.
                row_nxt  = row_r + 1'b1;
                col_nxt  = ghr_pkg::COL_W'(1);
                addr_nxt = addr_r + ghr_pkg::ADDR_W'(3);
              end
            end else begin
              col_nxt  = col_r + 1'b1;
              addr_nxt = addr_r + 1'b1;
            end
          end
          default: begin
            step_nxt = STEP_UP;
          end
        endcase
      end

      S_OUT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT_SEND;
      end

      S_OUT_SEND: begin
        if (out_ready) begin
          if (addr_r == ADDR_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_OUT_RD;
            if (col_r == COL_LAST) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= STEP_UP;
      row_r      <= '0;
      col_r      <= '0;
      addr_r     <= '0;
      load_idx_r <= '0;
      count_r    <= '0;
      calm_r     <= 1'b0;
      stable_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      addr_r     <= addr_nxt;
      load_idx_r <= load_idx_nxt;
      count_r    <= count_nxt;
      calm_r     <= calm_nxt;
      stable_r   <= stable_nxt;
    end
  end

  always_comb begin
    out_ctl.valid       = (state_r == S_OUT_SEND);
    out_ctl.row         = row_r;
    out_ctl.col         = col_r;
    out_ctl.stable      = stable_r;
    out_ctl.sweeps_done = count_r;
    out_ctl.last        = (addr_r == ADDR_LAST);
  end

endmodule

[rtl/core/grid_heat_relaxation_core.sv]
// Channel   Direction  Payload                                           Accepted when
// in_chan   input      kind, temperature                                 valid && ready
// out_chan  output     row, col, cell_value, stable, sweeps_done, last   valid && ready
// cfg_chan  input      index, data                                       valid && ready (ready out of reset)
//
// A load item produces nothing. A run item sweeps the interior cells repeatedly until a sweep
// leaves every cell within tolerance or the sweep limit is reached, six steps per cell (five
// reads of the single grid read port, then the update).
// The grid is then streamed out: each item is read in S_OUT_RD, then held in S_OUT_SEND until taken.
// Input is taken only while idle. Reset clears the control state, bank select and config registers;
// grid contents are undefined until loaded, and there is no clearing pass.
module grid_heat_relaxation_core (
  input  logic        clk,
  input  logic        rst_n,
  ghr_in_if.sink      in_chan,
  ghr_out_if.source   out_chan,
  ghr_cfg_if.sink     cfg_chan
);

  ghr_pkg::ghr_cmd_t              cmd;
  ghr_pkg::ghr_stat_t             stat;
  ghr_pkg::ghr_out_ctl_t          out_ctl;
  logic [ghr_pkg::TOL_W-1:0]      tolerance;
  logic [ghr_pkg::TEMP_W-1:0]     rd_data;

  ghr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_chan  (cfg_chan),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd),
    .out_ctl   (out_ctl),
    .tolerance (tolerance)
  );

  ghr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .load_data (in_chan.temperature),
    .tolerance (tolerance),
    .stat      (stat),
    .rd_data   (rd_data)
  );

  assign out_chan.valid       = out_ctl.valid;
  assign out_chan.row         = out_ctl.row;
  assign out_chan.col         = out_ctl.col;
  assign out_chan.cell_value  = rd_data;
  assign out_chan.stable      = out_ctl.stable;
  assign out_chan.sweeps_done = out_ctl.sweeps_done;
  assign out_chan.last        = out_ctl.last;

endmodule
